/* rtl/csv_column_type_checker_assert.svh */
// Assertion macros for the CSV column type checker.
// CCT_ASSERT_AT names its clock and reset; CCT_ASSERT uses clk_i and rst_ni.
`ifndef CSV_COLUMN_TYPE_CHECKER_ASSERT_SVH
`define CSV_COLUMN_TYPE_CHECKER_ASSERT_SVH

`ifndef SYNTHESIS
`define CCT_ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define CCT_ASSERT(lbl, prop, msg) \
  `CCT_ASSERT_AT(lbl, clk_i, rst_ni, prop, msg)
`else
`define CCT_ASSERT_AT(lbl, clk, rstn, prop, msg)
`define CCT_ASSERT(lbl, prop, msg)
`endif

`endif

/* rtl/cct_pkg.sv */
package cct_pkg;

  localparam int MAX_COLUMNS = 64;
  localparam int COL_W       = $clog2(MAX_COLUMNS + 1);
  localparam int ADDR_W      = $clog2(MAX_COLUMNS);

  localparam logic [7:0] CHAR_NL    = 8'd10;
  localparam logic [7:0] CHAR_COMMA = 8'd44;
  localparam logic [7:0] CHAR_DOT   = 8'd46;
  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_NINE  = 8'd57;

  typedef enum logic [1:0] {
    KIND_INT    = 2'd0,
    KIND_DOUBLE = 2'd1,
    KIND_STRING = 2'd2,
    KIND_EMPTY  = 2'd3
  } cell_kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_TYPE  = 2'd1,
    ST_COUNT = 2'd2,
    ST_WIDE  = 2'd3
  } status_e;

  // Type table access: one write and one read port
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    cell_kind_e        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

/* rtl/cct_type_ram.sv */
module cct_type_ram import cct_pkg::*; (
  input  logic       clk_i,
  input  ram_req_t   req_i,
  output cell_kind_e rdata_o
);

  cell_kind_e mem_q [MAX_COLUMNS];

  // Read-first: a read never meets a write to the same entry in one cycle
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_o <= mem_q[req_i.raddr];
    end
  end

endmodule

/* rtl/csv_column_type_checker.sv */
// CSV column type checker. Takes one raw CSV byte per transaction on the slave
// side and gives one result transaction per comma or newline on the master
// side: the kind of the cell just ended (int, double, string, empty), its
// column, whether it closed the row (tlast), whether it belongs to a skipped
// header row, and a status. The first data row records the column types in a
// 64-entry type table held in a synchronous RAM; every later row is checked
// against it and against the width of the first row of the stream. The first
// non-zero status is delivered and then the block goes silent: bytes are
// still taken but produce nothing until reset. An unclosed last cell gives
// no result. Rate: one byte per clock cycle, sustained, while results
// are taken. A delimiter issues its table read in the cycle it is taken and
// is resolved in the next cycle when the RAM data arrives, and the result
// then goes out through the output register. While a result waits on a
// stalled master side, bytes keep flowing until the next delimiter reaches
// the resolve stage; tready then stays low until the waiting result is taken.
// The header_present register (reset 1) is written through cfg_we_i/cfg_wdata_i;
// the user must write it only while idle, as the block does not enforce it.
`include "csv_column_type_checker_assert.svh"

module csv_column_type_checker import cct_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: header_present
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  // input bytes
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  // results
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [6:0] column_index, [8:7] status, rest zero
  output logic [2:0]  m_axis_tuser_o,   // [1:0] cell_kind, [2] header_row
  output logic        m_axis_tlast_o    // row_end
);

  localparam logic [1:0] PH_FIRST = 2'd0;  // first row of the stream
  localparam logic [1:0] PH_FILL  = 2'd1;  // first data row after a header
  localparam logic [1:0] PH_CHECK = 2'd2;  // checked rows

  localparam int ODW = ((COL_W + 2 + 7) / 8) * 8;

  // ---------------------------------------------------------------------------
  // Front stage: cell classification, counters and table access
  // ---------------------------------------------------------------------------
  logic             hdr_present_q;
  logic [1:0]       row_phase_q, row_phase_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [COL_W-1:0] type_count_q, type_count_d;
  logic [COL_W-1:0] first_width_q, first_width_d;
  logic [1:0]       dot_count_q, dot_count_d;
  logic             nonempty_q, nonempty_d;
  logic             nondigit_q, nondigit_d;
  logic             failed_q, failed_d;

  logic       in_acc;
  logic       is_nl, is_delim, is_digit;
  logic       is_header, is_fill, checking;
  logic       col_wide, table_full, row_over;
  logic       count_ok, expect_empty, need_cmp;
  cell_kind_e kind_now;
  status_e    pre_status;
  ram_req_t   ram_req;
  cell_kind_e ram_rdata;
  logic       s1_load, s1_adv;

  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign is_nl    = (s_axis_tdata_i == CHAR_NL);
  assign is_delim = is_nl || (s_axis_tdata_i == CHAR_COMMA);
  assign is_digit = (s_axis_tdata_i >= CHAR_ZERO) && (s_axis_tdata_i <= CHAR_NINE);

  always_comb begin
    if (!nonempty_q) begin
      kind_now = KIND_EMPTY;
    end else if (nondigit_q || (dot_count_q >= 2'd2)) begin
      kind_now = KIND_STRING;
    end else if (dot_count_q == 2'd1) begin
      kind_now = KIND_DOUBLE;
    end else begin
      kind_now = KIND_INT;
    end
  end

  assign is_header  = (row_phase_q == PH_FIRST) && hdr_present_q;
  assign is_fill    = (row_phase_q == PH_FILL) || ((row_phase_q == PH_FIRST) && !hdr_present_q);
  assign checking   = !is_header && !is_fill;
  assign col_wide   = (col_q >= COL_W'(MAX_COLUMNS));
  assign table_full = (type_count_q >= COL_W'(MAX_COLUMNS));
  assign row_over   = !is_nl && (col_q >= type_count_q);

  // Width errors are known here; type and count checks wait for the RAM
  always_comb begin
    if (col_wide) begin
      pre_status = ST_WIDE;
    end else if (is_fill && table_full) begin
      pre_status = ST_WIDE;
    end else if (checking && row_over) begin
      pre_status = ST_WIDE;
    end else begin
      pre_status = ST_OK;
    end
  end

  assign need_cmp     = checking && (pre_status == ST_OK);
  assign expect_empty = is_nl && (type_count_q == '0);
  assign count_ok     = ({1'b0, type_count_q} == ({1'b0, col_q} + 1'b1))
                        && (type_count_q == first_width_q);

  // Fill rows only write, checked rows only read: no overlap on one entry
  always_comb begin
    ram_req.we    = in_acc && !failed_q && is_delim && is_fill && !col_wide && !table_full;
    ram_req.waddr = type_count_q[ADDR_W-1:0];
    ram_req.wdata = kind_now;
    ram_req.re    = in_acc && !failed_q && is_delim && need_cmp;
    ram_req.raddr = is_nl ? ADDR_W'(type_count_q - 1'b1) : col_q[ADDR_W-1:0];
  end

  cct_type_ram u_type_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  // Advance counters as if the cell passes; an error stops everything anyway
  always_comb begin
    row_phase_d   = row_phase_q;
    col_d         = col_q;
    type_count_d  = type_count_q;
    first_width_d = first_width_q;
    dot_count_d   = dot_count_q;
    nonempty_d    = nonempty_q;
    nondigit_d    = nondigit_q;
    if (in_acc && !failed_q) begin
      if (!is_delim) begin
        nonempty_d = 1'b1;
        if (s_axis_tdata_i == CHAR_DOT) begin
          if (dot_count_q < 2'd2) begin
            dot_count_d = dot_count_q + 2'd1;
          end
        end else if (!is_digit) begin
          nondigit_d = 1'b1;
        end
      end else begin
        dot_count_d = '0;
        nonempty_d  = 1'b0;
        nondigit_d  = 1'b0;
        if (ram_req.we) begin
          type_count_d = type_count_q + 1'b1;
        end
        if (is_nl) begin
          if (row_phase_q == PH_FIRST) begin
            first_width_d = col_q + 1'b1;
          end
          row_phase_d = is_header ? PH_FILL : PH_CHECK;
          col_d       = '0;
        end else if (!col_wide) begin
          col_d = col_q + 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Resolve stage: compare with the table entry read for this cell
  // ---------------------------------------------------------------------------
  logic             s1_valid_q;
  cell_kind_e       s1_kind_q;
  logic [COL_W-1:0] s1_col_q;
  logic             s1_nl_q, s1_hdr_q, s1_cmp_q, s1_exp_empty_q, s1_count_ok_q;
  status_e          s1_pre_q;
  cell_kind_e       expected;
  status_e          s1_status;

  logic             m_valid_q;
  cell_kind_e       m_kind_q;
  logic [COL_W-1:0] m_col_q;
  logic             m_nl_q, m_hdr_q;
  status_e          m_status_q;
  logic             out_load;

  assign s1_load         = in_acc && is_delim && !failed_q;
  assign s1_adv          = s1_valid_q && (!m_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !s1_valid_q || s1_adv;

  assign expected = s1_exp_empty_q ? KIND_EMPTY : ram_rdata;

  always_comb begin
    if (s1_pre_q != ST_OK) begin
      s1_status = s1_pre_q;
    end else if (s1_cmp_q && (expected != s1_kind_q)) begin
      s1_status = ST_TYPE;
    end else if (s1_cmp_q && s1_nl_q && !s1_count_ok_q) begin
      s1_status = ST_COUNT;
    end else begin
      s1_status = ST_OK;
    end
  end

  // Drop anything still in flight once an error has gone out
  assign out_load = s1_adv && !failed_q;
  assign failed_d = failed_q || (out_load && (s1_status != ST_OK));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_present_q <= 1'b1;
      row_phase_q   <= PH_FIRST;
      col_q         <= '0;
      type_count_q  <= '0;
      first_width_q <= '0;
      dot_count_q   <= '0;
      nonempty_q    <= 1'b0;
      nondigit_q    <= 1'b0;
      failed_q      <= 1'b0;
      s1_valid_q    <= 1'b0;
      m_valid_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        hdr_present_q <= cfg_wdata_i;
      end
      row_phase_q   <= row_phase_d;
      col_q         <= col_d;
      type_count_q  <= type_count_d;
      first_width_q <= first_width_d;
      dot_count_q   <= dot_count_d;
      nonempty_q    <= nonempty_d;
      nondigit_q    <= nondigit_d;
      failed_q      <= failed_d;
      if (s1_load) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: hold while stalled
  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_kind_q      <= kind_now;
      s1_col_q       <= col_q;
      s1_nl_q        <= is_nl;
      s1_hdr_q       <= is_header;
      s1_pre_q       <= pre_status;
      s1_cmp_q       <= need_cmp;
      s1_exp_empty_q <= expect_empty;
      s1_count_ok_q  <= count_ok;
    end
    if (out_load) begin
      m_kind_q   <= s1_kind_q;
      m_col_q    <= s1_col_q;
      m_nl_q     <= s1_nl_q;
      m_hdr_q    <= s1_hdr_q;
      m_status_q <= s1_status;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = ODW'({m_status_q, m_col_q});
  assign m_axis_tuser_o  = {m_hdr_q, m_kind_q};
  assign m_axis_tlast_o  = m_nl_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `CCT_ASSERT(a_silent_after_error, failed_q && !m_valid_q |=> !m_valid_q, "result after error")
  `CCT_ASSERT(a_error_marks_failed, m_valid_q && (m_status_q != ST_OK) |-> failed_q, "not sticky")
  `CCT_ASSERT(a_no_read_with_write, !(ram_req.we && ram_req.re), "table read and write together")
  `CCT_ASSERT(a_stall_holds_stage, s1_valid_q && !s1_adv |=> s1_valid_q && $stable(s1_col_q), "lost")

endmodule
